### rtl/bounded_deque_with_search_core_defines.svh
// Assertion macros shared by the deque checker.
// Plain text only; depends on nothing else in the project.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, disabled while reset is asserted
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

### rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with search.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdq_pkg;

    localparam int CMD_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 3;
    // cmd + value packed, padded to whole bytes
    localparam int IN_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_DUMP       = 3'd5
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FOUND     = 3'd0,
        KIND_NOT_FOUND = 3'd1,
        KIND_EMPTY     = 3'd2,
        KIND_ELEMENT   = 3'd3,
        KIND_FULL      = 3'd4
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // One result item on its way to the output register
    typedef struct packed {
        kind_t                     kind;
        logic signed [VALUE_W-1:0] element;
        logic                      last;
    } result_t;

endpackage

`default_nettype wire

### rtl/bdq_store.sv
// Ring store of the deque: one write port, one read port, registered read data.
// Depends on bdq_pkg for the value width.
`default_nettype none

module bdq_store
    import bdq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IW       = 6
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [IW-1:0]      waddr,
    input  wire logic [VALUE_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [IW-1:0]      raddr,
    output logic      [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [CAPACITY];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/bdq_outreg.sv
// Output register of the deque: holds one result transaction until taken.
// Depends on bdq_pkg for result_t.
`default_nettype none

module bdq_outreg
    import bdq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire result_t            res,
    output logic                    room,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [VALUE_W-1:0] m_axis_tdata,  // element[31:0]
    output logic      [KIND_W-1:0]  m_axis_tuser,  // kind[2:0]
    output logic                    m_axis_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or being drained this cycle
    assign room       = !valid_reg || m_axis_tready;
    assign valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.element;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;

endmodule

`default_nettype wire

### rtl/bdq_ctrl.sv
// Deque sequencer: front/count pointers, push/pop updates and the search/dump walk.
// Depends on bdq_pkg; drives bdq_store and bdq_outreg.
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IW       = 6,
    parameter int CW       = 7
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CMD_W-1:0]      in_cmd,
    input  wire logic [VALUE_W-1:0]    in_value,
    // store
    output logic                       we,
    output logic      [IW-1:0]         waddr,
    output logic      [VALUE_W-1:0]    wdata,
    output logic                       re,
    output logic      [IW-1:0]         raddr,
    input  wire logic [VALUE_W-1:0]    rdata,
    // results
    input  wire logic                  out_room,
    output logic                       emit,
    output result_t                    res
);

    localparam int SW = CW + 1;

    state_t             state_reg,     state_next;
    logic [IW-1:0]      front_reg,     front_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic [CW-1:0]      walk_idx_reg,  walk_idx_next;
    logic               data_vld_reg,  data_vld_next;
    logic               data_last_reg, data_last_next;
    logic               dump_reg,      dump_next;
    logic [VALUE_W-1:0] key_reg,       key_next;

    logic accept;
    logic full;
    logic consume;
    logic issue;
    logic hit;

    // Ring position at an offset from a base, wrapped modulo CAPACITY
    function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            walk_idx_reg  <= '0;
            data_vld_reg  <= 1'b0;
            data_last_reg <= 1'b0;
            dump_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            walk_idx_reg  <= walk_idx_next;
            data_vld_reg  <= data_vld_next;
            data_last_reg <= data_last_next;
            dump_reg      <= dump_next;
        end
    end

    // Search key, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign full    = (count_reg == CW'(CAPACITY));
    assign in_ready = (state_reg == ST_IDLE) && out_room;
    assign accept  = in_valid && in_ready;
    assign consume = (state_reg == ST_WALK) && data_vld_reg && out_room;
    assign issue   = (state_reg == ST_WALK) && (walk_idx_reg != count_reg)
                     && (!data_vld_reg || consume);
    assign hit     = (rdata == key_reg);

    // Next state, pointer updates, store access and result emission
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        walk_idx_next  = walk_idx_reg;
        data_vld_next  = data_vld_reg;
        data_last_next = data_last_reg;
        dump_next      = dump_reg;
        key_next       = key_reg;
        we             = 1'b0;
        waddr          = slot_at(front_reg, count_reg);
        wdata          = in_value;
        re             = 1'b0;
        raddr          = slot_at(front_reg, walk_idx_reg);
        emit           = 1'b0;
        res.kind       = KIND_EMPTY;
        res.element    = '0;
        res.last       = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(in_cmd))
                        CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                emit     = 1'b1;
                                res.kind = KIND_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? IW'(CAPACITY - 1)
                                                               : front_reg - 1'b1;
                                we         = 1'b1;
                                waddr      = front_next;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                emit     = 1'b1;
                                res.kind = KIND_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (count_reg != '0)
                            begin
                                front_next = (front_reg == IW'(CAPACITY - 1)) ? '0
                                                                              : front_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_SEARCH, CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit     = 1'b1;
                                res.kind = KIND_EMPTY;
                            end
                            else
                            begin
                                state_next    = ST_WALK;
                                walk_idx_next = '0;
                                data_vld_next = 1'b0;
                                dump_next     = (cmd_t'(in_cmd) == CMD_DUMP);
                                key_next      = in_value;
                            end
                        end
                        default:
                        begin
                            // unused codes: no effect
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // read ahead one entry while the previous one is consumed
                if (issue)
                begin
                    re             = 1'b1;
                    walk_idx_next  = walk_idx_reg + 1'b1;
                    data_vld_next  = 1'b1;
                    data_last_next = (walk_idx_next == count_reg);
                end
                else if (consume)
                begin
                    data_vld_next = 1'b0;
                end

                if (consume)
                begin
                    if (dump_reg)
                    begin
                        emit        = 1'b1;
                        res.kind    = KIND_ELEMENT;
                        res.element = rdata;
                        res.last    = data_last_reg;
                        if (data_last_reg)
                        begin
                            state_next    = ST_IDLE;
                            data_vld_next = 1'b0;
                        end
                    end
                    else if (hit || data_last_reg)
                    begin
                        emit          = 1'b1;
                        res.kind      = hit ? KIND_FOUND : KIND_NOT_FOUND;
                        state_next    = ST_IDLE;
                        data_vld_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/bounded_deque_with_search_core.sv
// Top level of the bounded deque with search; ties sequencer, store and output register.
// Depends on bdq_pkg, bdq_ctrl, bdq_store and bdq_outreg.
`default_nettype none

// Bounded double-ended queue of signed 32-bit values in a ring store of CAPACITY
// entries (2..64). Each s_axis transaction carries one command: push front, push
// back, pop front, pop back, search or dump. Pushes and pops complete when taken and
// give no result, except a push into a full store, which is dropped and gives one
// FULL result. Search gives one result (found, not found, empty); dump gives one
// ELEMENT result per held entry, front first, tlast on the final one, or a single
// EMPTY result. Search and dump walk the store through its single read port, one
// entry per cycle while m_axis does not stall, with registered read data; a new
// command is taken only after the walk ends. There is no clearing pass after reset;
// s_axis_tready rises as soon as reset is released and the output register has
// room.

module bounded_deque_with_search_core
    import bdq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // cmd[2:0], value[34:3], zero pad
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [VALUE_W-1:0]    m_axis_tdata,  // element[31:0]
    output logic      [KIND_W-1:0]     m_axis_tuser,  // kind[2:0]
    output logic                       m_axis_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic               we;
    logic [IW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [IW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata;
    logic               out_room;
    logic               emit;
    result_t            res;

    // Command sequencer
    bdq_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tdata[CMD_W-1:0]),
        .in_value (s_axis_tdata[CMD_W+VALUE_W-1:CMD_W]),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .re       (re),
        .raddr    (raddr),
        .rdata    (rdata),
        .out_room (out_room),
        .emit     (emit),
        .res      (res)
    );

    // Ring store
    bdq_store #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result register
    bdq_outreg u_outreg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .res           (res),
        .room          (out_room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### rtl/bdq_checker.sv
// Port-level checks for the bounded deque, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_search_core_defines.svh.
`default_nettype none

`include "bounded_deque_with_search_core_defines.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [VALUE_W-1:0]    m_axis_tdata,
    input wire logic [KIND_W-1:0]     m_axis_tuser,
    input wire logic                  m_axis_tlast
);

    // Stalled result stays valid
    `BDQ_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Stalled result keeps its payload
    `BDQ_ASSERT_NEXT(a_hold_data, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Only dumped elements carry data
    `BDQ_ASSERT_NOW(a_zero_data, clk, rst_n, m_axis_tvalid && (m_axis_tuser != KIND_ELEMENT), m_axis_tdata == '0)

    // Status results are single-transaction responses
    `BDQ_ASSERT_NOW(a_status_last, clk, rst_n, m_axis_tvalid && (m_axis_tuser != KIND_ELEMENT), m_axis_tlast)

    // No new command while a dump is still streaming
    `BDQ_ASSERT_NOW(a_busy_dump, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind bounded_deque_with_search_core bdq_checker u_bdq_checker (.*);

`default_nettype wire
